FILE: design/uart_buffered_byte_queues_top_macros.svh
// ----------------------------------------------------------------------------
// UART byte queues assertion macros
// Shared assertion forms for the UART byte queue checker.
// ----------------------------------------------------------------------------
`ifndef UART_BUFFERED_BYTE_QUEUES_TOP_MACROS_SVH
`define UART_BUFFERED_BYTE_QUEUES_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UBBQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ubbq checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define UBBQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ubbq checker: next-cycle property failed");

`endif

FILE: design/ubbq_pkg.sv
// ----------------------------------------------------------------------------
// UART byte queues package
// Depths, characters, request codes and beat types of the UART byte queues.
// ----------------------------------------------------------------------------
package ubbq_pkg;

  localparam int unsigned TX_DEPTH = 256;
  localparam int unsigned RX_DEPTH = 16;

  localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [2:0] {
    REQ_RX_BYTE  = 3'd0,
    REQ_TX_READY = 3'd1,
    REQ_HOST_WR  = 3'd2,
    REQ_HOST_RD  = 3'd3,
    REQ_RX_CLEAR = 3'd4
  } req_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_ok;
    logic       input_available;
    logic       overrun;
    logic       tx_pending;
  } res_t;

endpackage

FILE: design/ubbq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module ubbq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/uart_buffered_byte_queues_top.sv
// ----------------------------------------------------------------------------
// UART buffered byte queues
// Transmit and receive ring queues in RAM with CR/LF handling, echo and
// sticky receive overrun.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Beat
// command   in         start and not busy        req_i
// result    out        res_valid_o strobe        res_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (echo enable)
//
// Most commands complete in ST_IDLE and their result strobes in the next cycle.
// A line feed queued for transmit is written as CR in ST_IDLE, then LF in ST_PUSH2.
// A dequeue passes through ST_TXRD or ST_RXRD for the registered RAM read.
// Reset clears pointers, counts and flags; no clearing pass is needed.
// The result receiver cannot stall; the config port is always ready.
// ----------------------------------------------------------------------------
module uart_buffered_byte_queues_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ubbq_pkg::req_t req_i,
  output logic           res_valid_o,
  output ubbq_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  import ubbq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PUSH2 = 4'b0010,
    ST_TXRD  = 4'b0100,
    ST_RXRD  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [TX_AW-1:0] tx_wi_q, tx_wi_d, tx_ri_q, tx_ri_d;
  logic [TX_CW-1:0] tx_cnt_q, tx_cnt_d;
  logic [RX_AW-1:0] rx_wi_q, rx_wi_d, rx_ri_q, rx_ri_d;
  logic [RX_CW-1:0] rx_cnt_q, rx_cnt_d;
  logic             overrun_q, overrun_d;
  logic             echo_q, echo_d;
  logic             ok_q, ok_d;
  logic             res_vld_q, res_vld_d;
  res_t             res_q, res_d;

  logic             tx_we, tx_re;
  logic [7:0]       tx_wdata, tx_rdata;
  logic             rx_we, rx_re;
  logic [7:0]       rx_wdata, rx_rdata;
  logic             tx_full;
  logic [7:0]       first_byte;

  ubbq_ram #(.Width(8), .Depth(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wi_q),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_ri_q),
    .rdata_o (tx_rdata)
  );

  ubbq_ram #(.Width(8), .Depth(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wi_q),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_ri_q),
    .rdata_o (rx_rdata)
  );

  assign tx_full    = (tx_cnt_q == TX_CW'(TX_DEPTH));
  assign first_byte = (req_i.data_byte == CHAR_LF) ? CHAR_CR : req_i.data_byte;
  assign echo_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : echo_q;

  always_comb begin
    state_d   = state_q;
    tx_wi_d   = tx_wi_q;
    tx_ri_d   = tx_ri_q;
    tx_cnt_d  = tx_cnt_q;
    rx_wi_d   = rx_wi_q;
    rx_ri_d   = rx_ri_q;
    rx_cnt_d  = rx_cnt_q;
    overrun_d = overrun_q;
    ok_d      = ok_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    tx_wdata  = first_byte;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    rx_wdata  = (req_i.data_byte == CHAR_CR) ? CHAR_LF : req_i.data_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          res_d = '0;
          ok_d  = 1'b1;
          unique case (req_i.req_type)
            REQ_RX_BYTE, REQ_HOST_WR: begin
              if (req_i.req_type == REQ_HOST_WR || echo_q) begin
                if (tx_full) begin
                  ok_d = 1'b0;
                end else begin
                  tx_we    = 1'b1;
                  tx_wi_d  = (tx_wi_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wi_q + 1'b1;
                  tx_cnt_d = tx_cnt_q + 1'b1;
                end
                if (req_i.data_byte == CHAR_LF) begin
                  state_d = ST_PUSH2;
                end
              end
              if (req_i.req_type == REQ_RX_BYTE) begin
                if (rx_cnt_q == RX_CW'(RX_DEPTH)) begin
                  overrun_d = 1'b1;
                end else begin
                  rx_we    = 1'b1;
                  rx_wi_d  = (rx_wi_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wi_q + 1'b1;
                  rx_cnt_d = rx_cnt_q + 1'b1;
                end
              end
            end
            REQ_TX_READY: begin
              if (tx_cnt_q != '0) begin
                tx_re    = 1'b1;
                tx_ri_d  = (tx_ri_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_ri_q + 1'b1;
                tx_cnt_d = tx_cnt_q - 1'b1;
                state_d  = ST_TXRD;
              end
            end
            REQ_HOST_RD: begin
              if (rx_cnt_q != '0) begin
                rx_re    = 1'b1;
                rx_ri_d  = (rx_ri_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_ri_q + 1'b1;
                rx_cnt_d = rx_cnt_q - 1'b1;
                state_d  = ST_RXRD;
              end
            end
            REQ_RX_CLEAR: begin
              rx_wi_d  = '0;
              rx_ri_d  = '0;
              rx_cnt_d = '0;
            end
            default: begin
            end
          endcase
          res_vld_d = (state_d == ST_IDLE);
        end
      end
      ST_PUSH2: begin
        tx_wdata = CHAR_LF;
        if (tx_full) begin
          ok_d = 1'b0;
        end else begin
          tx_we    = 1'b1;
          tx_wi_d  = (tx_wi_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wi_q + 1'b1;
          tx_cnt_d = tx_cnt_q + 1'b1;
        end
        state_d   = ST_IDLE;
        res_vld_d = 1'b1;
      end
      ST_TXRD: begin
        res_d.tx_valid = 1'b1;
        res_d.tx_byte  = tx_rdata;
        state_d        = ST_IDLE;
        res_vld_d      = 1'b1;
      end
      ST_RXRD: begin
        res_d.read_valid = 1'b1;
        res_d.read_byte  = rx_rdata;
        state_d          = ST_IDLE;
        res_vld_d        = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (res_vld_d) begin
      res_d.write_ok        = ok_d;
      res_d.input_available = (rx_cnt_d != '0);
      res_d.overrun         = overrun_d;
      res_d.tx_pending      = (tx_cnt_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tx_wi_q   <= '0;
      tx_ri_q   <= '0;
      tx_cnt_q  <= '0;
      rx_wi_q   <= '0;
      rx_ri_q   <= '0;
      rx_cnt_q  <= '0;
      overrun_q <= 1'b0;
      echo_q    <= 1'b0;
      ok_q      <= 1'b1;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tx_wi_q   <= tx_wi_d;
      tx_ri_q   <= tx_ri_d;
      tx_cnt_q  <= tx_cnt_d;
      rx_wi_q   <= rx_wi_d;
      rx_ri_q   <= rx_ri_d;
      rx_cnt_q  <= rx_cnt_d;
      overrun_q <= overrun_d;
      echo_q    <= echo_d;
      ok_q      <= ok_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule

FILE: design/ubbq_checker.sv
// ----------------------------------------------------------------------------
// UART byte queues checker
// Port-level properties of the UART byte queues, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_buffered_byte_queues_top_macros.svh"

module ubbq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input ubbq_pkg::req_t req_i,
  input logic           res_valid_o,
  input ubbq_pkg::res_t res_o
);

  import ubbq_pkg::*;

  logic no_byte_valid;
  logic bytes_zero;
  logic clear_beat;

  assign no_byte_valid = res_valid_o && !res_o.tx_valid && !res_o.read_valid;
  assign bytes_zero    = (res_o.tx_byte == 8'h00) && (res_o.read_byte == 8'h00);
  assign clear_beat    = start && !busy && (req_i.req_type == REQ_RX_CLEAR);

  `UBBQ_ASSERT_NEXT(a_accept_progress, start && !busy, res_valid_o || busy)
  `UBBQ_ASSERT_NOW(a_no_result_while_busy, busy, !res_valid_o)
  `UBBQ_ASSERT_NOW(a_byte_zero_without_valid, no_byte_valid, bytes_zero)
  `UBBQ_ASSERT_NEXT(a_clear_empties_rx, clear_beat, res_valid_o && !res_o.input_available)

endmodule

bind uart_buffered_byte_queues_top ubbq_checker u_ubbq_checker (.*);
